// ===== hdl/safety_level_escalation_fsm_assert.svh =====
// Assertion helpers included by the core design file.
`ifndef SAFETY_LEVEL_ESCALATION_FSM_ASSERT_SVH
`define SAFETY_LEVEL_ESCALATION_FSM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLEF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slef assertion failed");

// Next-cycle implication, disabled during reset.
`define SLEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slef assertion failed");

`endif

// ===== hdl/slef_pkg.sv =====
package slef_pkg;

    localparam int LEVEL_W       = 3;
    localparam int NOW_W         = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [CFG_W-1:0] DELAY_RST   = 16'd100;
    localparam logic [CFG_W-1:0] DWELL_RST   = 16'd5000;
    localparam logic [CFG_W-1:0] REFRESH_RST = 16'd100;

    localparam logic [LEVEL_W-1:0] LVL_NORMAL     = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_MONITORING = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_WARNING    = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL   = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_EMERGENCY  = 3'd4;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED = 2'd0,
        CFG_DELAY   = 2'd1,
        CFG_DWELL   = 2'd2,
        CFG_REFRESH = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PAT_NONE    = 3'd0,
        PAT_SOLID   = 3'd1,
        PAT_SLOW    = 3'd2,
        PAT_FAST    = 3'd3,
        PAT_PULSE   = 3'd4,
        PAT_ERROR   = 3'd5,
        PAT_WARNING = 3'd6
    } t_led_pat;

    typedef struct packed {
        t_led_pat system_led;
        t_led_pat comm_led;
        t_led_pat network_led;
        t_led_pat error_led;
        t_led_pat power_led;
    } t_led_set;

    typedef struct packed {
        logic             enabled;
        logic [CFG_W-1:0] transition_delay_ms;
        logic [CFG_W-1:0] min_dwell_ms;
        logic [CFG_W-1:0] led_refresh_ms;
    } t_cfg;

    typedef struct packed {
        logic               operation;
        logic [NOW_W-1:0]   now_ms;
        logic [LEVEL_W-1:0] requested_level;
        logic [LEVEL_W-1:0] detector_level;
        logic               detector_valid;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] active_level;
        logic [LEVEL_W-1:0] target_level;
        logic               transitioning;
        logic               safe_state;
        logic               needs_attention;
        logic               led_refresh;
        t_led_set           leds;
        logic               status;
    } t_result;

    // Codes 5..7 mean emergency.
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
        return (lvl > LVL_EMERGENCY) ? LVL_EMERGENCY : lvl;
    endfunction

    function automatic t_led_set led_for_level(input logic [LEVEL_W-1:0] lvl);
        t_led_set s;
        unique case (lvl)
            LVL_NORMAL:     s = '{PAT_SOLID, PAT_SOLID,   PAT_SOLID, PAT_NONE,  PAT_SOLID};
            LVL_MONITORING: s = '{PAT_SLOW,  PAT_SOLID,   PAT_SOLID, PAT_NONE,  PAT_SOLID};
            LVL_WARNING:    s = '{PAT_SOLID, PAT_WARNING, PAT_SOLID, PAT_SLOW,  PAT_SOLID};
            LVL_CRITICAL:   s = '{PAT_FAST,  PAT_ERROR,   PAT_SLOW,  PAT_FAST,  PAT_SLOW};
            default:        s = '{PAT_ERROR, PAT_ERROR,   PAT_ERROR, PAT_SOLID, PAT_ERROR};
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/slef_ifaces.sv =====
interface slef_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [slef_pkg::CFG_IDX_W-1:0] index;
    logic [slef_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface slef_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [slef_pkg::NOW_W-1:0]   now_ms;
    logic [slef_pkg::LEVEL_W-1:0] requested_level;
    logic [slef_pkg::LEVEL_W-1:0] detector_level;
    logic                         detector_valid;

    modport source (output valid, output operation, output now_ms, output requested_level,
                    output detector_level, output detector_valid, input ready);
    modport sink   (input valid, input operation, input now_ms, input requested_level,
                    input detector_level, input detector_valid, output ready);
endinterface

interface slef_out_if;
    logic                         valid;
    logic                         ready;
    logic [slef_pkg::LEVEL_W-1:0] active_level;
    logic [slef_pkg::LEVEL_W-1:0] target_level;
    logic                         transitioning;
    logic                         safe_state;
    logic                         needs_attention;
    logic                         led_refresh;
    logic [2:0]                   system_led;
    logic [2:0]                   comm_led;
    logic [2:0]                   network_led;
    logic [2:0]                   error_led;
    logic [2:0]                   power_led;
    logic                         status;

    modport source (output valid, output active_level, output target_level,
                    output transitioning, output safe_state, output needs_attention,
                    output led_refresh, output system_led, output comm_led,
                    output network_led, output error_led, output power_led,
                    output status, input ready);
    modport sink   (input valid, input active_level, input target_level,
                    input transitioning, input safe_state, input needs_attention,
                    input led_refresh, input system_led, input comm_led,
                    input network_led, input error_led, input power_led,
                    input status, output ready);
endinterface

// ===== hdl/safety_level_escalation_fsm.sv =====
// Channel   Direction  Moves
// i_cfg     in         register write: index, data (always ready)
// i_item    in         item: tick or level request with timestamp
// o_res     out        one result item per input item
//
// One item per cycle sustained while o_res.ready stays high; a result becomes valid once
// its item has passed the input register, then the state update and result register.
// Ready on i_item follows o_res.ready through both registers, no bubbles.
// Synchronous active-low reset: level normal, no pending transition, timestamps 0,
// registers at their defaults with the block disabled.
module safety_level_escalation_fsm #(
    parameter int TIME_BITS = slef_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slef_cfg_if.sink   i_cfg,
    slef_in_if.sink    i_item,
    slef_out_if.source o_res
);
    import slef_pkg::*;

    t_cfg    w_cfg;
    logic    w_stage_valid;
    t_item   w_stage_item;
    logic    w_core_ready;
    t_result w_res;

    slef_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    slef_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_down_ready (w_core_ready),
        .o_valid      (w_stage_valid),
        .o_item       (w_stage_item)
    );

    slef_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_stage_valid),
        .i_item      (w_stage_item),
        .o_up_ready  (w_core_ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign o_res.active_level    = w_res.active_level;
    assign o_res.target_level    = w_res.target_level;
    assign o_res.transitioning   = w_res.transitioning;
    assign o_res.safe_state      = w_res.safe_state;
    assign o_res.needs_attention = w_res.needs_attention;
    assign o_res.led_refresh     = w_res.led_refresh;
    assign o_res.system_led      = w_res.leds.system_led;
    assign o_res.comm_led        = w_res.leds.comm_led;
    assign o_res.network_led     = w_res.leds.network_led;
    assign o_res.error_led       = w_res.leds.error_led;
    assign o_res.power_led       = w_res.leds.power_led;
    assign o_res.status          = w_res.status;

endmodule

// ===== hdl/slef_cfg_regs.sv =====
module slef_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slef_cfg_if.sink          i_cfg,
    output slef_pkg::t_cfg    o_cfg
);
    import slef_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled             <= 1'b0;
            r_cfg.transition_delay_ms <= DELAY_RST;
            r_cfg.min_dwell_ms        <= DWELL_RST;
            r_cfg.led_refresh_ms      <= REFRESH_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ENABLED: r_cfg.enabled             <= i_cfg.data[0];
                CFG_DELAY:   r_cfg.transition_delay_ms <= i_cfg.data;
                CFG_DWELL:   r_cfg.min_dwell_ms        <= i_cfg.data;
                CFG_REFRESH: r_cfg.led_refresh_ms      <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/slef_in_reg.sv =====
module slef_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slef_in_if.sink         i_item,
    input  logic            i_down_ready,
    output logic            o_valid,
    output slef_pkg::t_item o_item
);
    import slef_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign i_item.ready = !r_valid || i_down_ready;
    assign w_load       = i_item.valid && i_item.ready;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.operation       <= i_item.operation;
            r_item.now_ms          <= i_item.now_ms;
            r_item.requested_level <= i_item.requested_level;
            r_item.detector_level  <= i_item.detector_level;
            r_item.detector_valid  <= i_item.detector_valid;
        end
    end

endmodule

// ===== hdl/slef_core.sv =====
module slef_core #(
    parameter int TIME_BITS = slef_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slef_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  slef_pkg::t_item   i_item,
    output logic              o_up_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output slef_pkg::t_result o_res
);
    import slef_pkg::*;

    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [LEVEL_W-1:0]   r_goal, n_goal;
    logic                 r_pending, n_pending;
    logic [TIME_BITS-1:0] r_since, n_since;
    logic [TIME_BITS-1:0] r_entered, n_entered;
    logic [TIME_BITS-1:0] r_last_ref, n_last_ref;
    logic                 r_res_valid;
    t_result              r_res, n_res;

    logic                 w_go;
    logic [63:0]          w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [LEVEL_W-1:0]   w_req;
    logic [LEVEL_W-1:0]   w_det;
    logic [TIME_BITS-1:0] w_delay, w_dwell, w_period;
    logic                 w_refresh;
    logic                 w_status;

    assign o_up_ready  = !r_res_valid || i_res_ready;
    assign w_go        = i_valid && o_up_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Time is carried modulo 2^TIME_BITS.
    assign w_now_ext = {{(64 - NOW_W){1'b0}}, i_item.now_ms};
    assign w_now     = w_now_ext[TIME_BITS-1:0];
    assign w_delay   = TIME_BITS'(i_cfg.transition_delay_ms);
    assign w_dwell   = TIME_BITS'(i_cfg.min_dwell_ms);
    assign w_period  = TIME_BITS'(i_cfg.led_refresh_ms);
    assign w_req     = clamp_level(i_item.requested_level);
    assign w_det     = clamp_level(i_item.detector_level);

    always_comb begin
        n_level    = r_level;
        n_goal     = r_goal;
        n_pending  = r_pending;
        n_since    = r_since;
        n_entered  = r_entered;
        n_last_ref = r_last_ref;
        w_refresh  = 1'b0;
        w_status   = STATUS_OK;

        if (!i_cfg.enabled) begin
            w_status = STATUS_ERR;
        end else if (i_item.operation == OP_REQUEST) begin
            if (w_req != r_level) begin
                n_pending = 1'b1;
                n_goal    = w_req;
                n_since   = w_now;
            end
        end else begin
            if (TIME_BITS'(w_now - r_last_ref) >= w_period) begin
                w_refresh  = 1'b1;
                n_last_ref = w_now;
            end
            if (r_pending && (TIME_BITS'(w_now - r_since) >= w_delay)) begin
                n_pending = 1'b0;
                n_level   = r_goal;
                n_entered = w_now;
            end
            // Follow the detector only when nothing is in flight.
            if (!n_pending && i_item.detector_valid) begin
                if (w_det < n_level) begin
                    if (TIME_BITS'(w_now - n_entered) >= w_dwell) begin
                        n_pending = 1'b1;
                        n_goal    = w_det;
                        n_since   = w_now;
                    end
                end else if (w_det > n_level) begin
                    n_pending = 1'b1;
                    n_goal    = w_det;
                    n_since   = w_now;
                end
            end
        end

        n_res.active_level    = n_level;
        n_res.target_level    = n_pending ? n_goal : n_level;
        n_res.transitioning   = n_pending;
        n_res.safe_state      = (n_level <= LVL_MONITORING);
        n_res.needs_attention = (n_level >= LVL_WARNING);
        n_res.led_refresh     = w_refresh;
        n_res.leds            = led_for_level(n_level);
        n_res.status          = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= LVL_NORMAL;
            r_goal     <= LVL_NORMAL;
            r_pending  <= 1'b0;
            r_since    <= '0;
            r_entered  <= '0;
            r_last_ref <= '0;
        end else if (w_go) begin
            r_level    <= n_level;
            r_goal     <= n_goal;
            r_pending  <= n_pending;
            r_since    <= n_since;
            r_entered  <= n_entered;
            r_last_ref <= n_last_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_res_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_res <= n_res;
        end
    end

`include "safety_level_escalation_fsm_assert.svh"

    `SLEF_ASSERT_NOW(a_goal_tracks_pending, i_clk, i_rst_n, 1'b1,
        ((r_goal == r_level) == !r_pending))
    `SLEF_ASSERT_NOW(a_level_in_range, i_clk, i_rst_n, 1'b1,
        ((r_level <= LVL_EMERGENCY) && (r_goal <= LVL_EMERGENCY)))
    `SLEF_ASSERT_NEXT(a_disabled_freezes, i_clk, i_rst_n, (w_go && !i_cfg.enabled),
        ($stable(r_level) && $stable(r_pending) && $stable(r_last_ref)
         && r_res.status == STATUS_ERR))
    `SLEF_ASSERT_NEXT(a_request_no_refresh, i_clk, i_rst_n,
        (w_go && i_item.operation == OP_REQUEST),
        (!r_res.led_refresh && $stable(r_level)))

endmodule

// ===== tb/sv/safety_level_escalation_fsm_tb.sv =====
module safety_level_escalation_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slef_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 12;
    localparam int HOLD_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct {
        bit               is_cfg;
        t_cfg_idx         reg_idx;
        logic [CFG_W-1:0] reg_val;
        t_item            it;
        bit               pinned;
        t_result          want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    slef_cfg_if cfg_if ();
    slef_in_if  item_if ();
    slef_out_if res_if ();

    safety_level_escalation_fsm u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    // predictor copy of the registers and level state
    logic               en_q;
    logic [CFG_W-1:0]   delay_q;
    logic [CFG_W-1:0]   dwell_q;
    logic [CFG_W-1:0]   period_q;
    logic [LEVEL_W-1:0] level_q;
    logic [LEVEL_W-1:0] goal_q;
    logic               pend_q;
    logic [NOW_W-1:0]   pend_start_q;
    logic [NOW_W-1:0]   entered_q;
    logic [NOW_W-1:0]   refreshed_q;

    t_result   expected_reports[$];
    t_stim_row pinned_reports[$];
    t_stim_row directed_steps[$];

    int  errors      = 0;
    int  cycle_count = 0;
    bit  gaps_on     = 1'b1;
    bit  stall_on    = 1'b1;
    bit  hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] lvl);
        return (lvl > LVL_EMERGENCY) ? LVL_EMERGENCY : lvl;
    endfunction

    function automatic t_led_set leds_of(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            LVL_NORMAL:     return {PAT_SOLID, PAT_SOLID, PAT_SOLID, PAT_NONE, PAT_SOLID};
            LVL_MONITORING: return {PAT_SLOW, PAT_SOLID, PAT_SOLID, PAT_NONE, PAT_SOLID};
            LVL_WARNING:    return {PAT_SOLID, PAT_WARNING, PAT_SOLID, PAT_SLOW, PAT_SOLID};
            LVL_CRITICAL:   return {PAT_FAST, PAT_ERROR, PAT_SLOW, PAT_FAST, PAT_SLOW};
            default:        return {PAT_ERROR, PAT_ERROR, PAT_ERROR, PAT_SOLID, PAT_ERROR};
        endcase
    endfunction

    // Advances the level state by one item and returns the report it produces.
    function automatic t_result escalate_step(input t_item it);
        t_result            r;
        logic [LEVEL_W-1:0] req;
        logic [LEVEL_W-1:0] det;
        logic [NOW_W-1:0]   t;
        req = cap_level(it.requested_level);
        det = cap_level(it.detector_level);
        t   = it.now_ms;
        r   = '0;
        r.status = STATUS_OK;
        if (!en_q) begin
            r.status = STATUS_ERR;
        end else if (it.operation == OP_REQUEST) begin
            if (req != level_q) begin
                pend_q       = 1'b1;
                goal_q       = req;
                pend_start_q = t;
            end
        end else begin
            if (NOW_W'(t - refreshed_q) >= period_q) begin
                r.led_refresh = 1'b1;
                refreshed_q   = t;
            end
            if (pend_q && NOW_W'(t - pend_start_q) >= delay_q) begin
                pend_q    = 1'b0;
                level_q   = goal_q;
                entered_q = t;
            end
            // detector only moves the level when nothing is pending;
            // going down waits out the dwell time
            if (!pend_q && it.detector_valid && det != level_q) begin
                if (det > level_q || NOW_W'(t - entered_q) >= dwell_q) begin
                    pend_q       = 1'b1;
                    goal_q       = det;
                    pend_start_q = t;
                end
            end
        end
        r.active_level    = level_q;
        r.target_level    = pend_q ? goal_q : level_q;
        r.transitioning   = pend_q;
        r.safe_state      = (level_q <= LVL_MONITORING);
        r.needs_attention = (level_q >= LVL_WARNING);
        r.leds            = leds_of(level_q);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_report(input t_result want, input t_result got);
        check_field("active_level", want.active_level, got.active_level);
        check_field("target_level", want.target_level, got.target_level);
        check_field("transitioning", want.transitioning, got.transitioning);
        check_field("safe_state", want.safe_state, got.safe_state);
        check_field("needs_attention", want.needs_attention, got.needs_attention);
        check_field("led_refresh", want.led_refresh, got.led_refresh);
        check_field("system_led", want.leds.system_led, got.leds.system_led);
        check_field("comm_led", want.leds.comm_led, got.leds.comm_led);
        check_field("network_led", want.leds.network_led, got.leds.network_led);
        check_field("error_led", want.leds.error_led, got.leds.error_led);
        check_field("power_led", want.leds.power_led, got.leds.power_led);
        check_field("status", want.status, got.status);
    endtask

    always @(posedge i_clk) begin
        t_item     it;
        t_result   got;
        t_result   want;
        t_stim_row pin;
        if (!i_rst_n) begin
            en_q         = 1'b0;
            delay_q      = DELAY_RST;
            dwell_q      = DWELL_RST;
            period_q     = REFRESH_RST;
            level_q      = LVL_NORMAL;
            goal_q       = LVL_NORMAL;
            pend_q       = 1'b0;
            pend_start_q = '0;
            entered_q    = '0;
            refreshed_q  = '0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_cfg_idx'(cfg_if.index))
                    CFG_ENABLED: en_q     = cfg_if.data[0];
                    CFG_DELAY:   delay_q  = cfg_if.data;
                    CFG_DWELL:   dwell_q  = cfg_if.data;
                    CFG_REFRESH: period_q = cfg_if.data;
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready) begin
                it.operation       = item_if.operation;
                it.now_ms          = item_if.now_ms;
                it.requested_level = item_if.requested_level;
                it.detector_level  = item_if.detector_level;
                it.detector_valid  = item_if.detector_valid;
                expected_reports.push_back(escalate_step(it));
            end
            if (res_if.valid && res_if.ready) begin
                got.active_level     = res_if.active_level;
                got.target_level     = res_if.target_level;
                got.transitioning    = res_if.transitioning;
                got.safe_state       = res_if.safe_state;
                got.needs_attention  = res_if.needs_attention;
                got.led_refresh      = res_if.led_refresh;
                got.leds.system_led  = t_led_pat'(res_if.system_led);
                got.leds.comm_led    = t_led_pat'(res_if.comm_led);
                got.leds.network_led = t_led_pat'(res_if.network_led);
                got.leds.error_led   = t_led_pat'(res_if.error_led);
                got.leds.power_led   = t_led_pat'(res_if.power_led);
                got.status           = res_if.status;
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t ns: result item with none expected, expected nothing, actual %p",
                             $time, got);
                end else begin
                    want = expected_reports.pop_front();
                    compare_report(want, got);
                    if (pinned_reports.size() != 0) begin
                        pin = pinned_reports.pop_front();
                        if (pin.pinned)
                            compare_report(pin.want, got);
                    end
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_item it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.operation       <= it.operation;
        item_if.now_ms          <= it.now_ms;
        item_if.requested_level <= it.requested_level;
        item_if.detector_level  <= it.detector_level;
        item_if.detector_valid  <= it.detector_valid;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    task automatic drain_reports();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        drain_reports();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_stim_row item_row(input logic op, input logic [NOW_W-1:0] t,
                                           input logic [LEVEL_W-1:0] req,
                                           input logic [LEVEL_W-1:0] det, input logic dv);
        t_stim_row s;
        s = '{reg_idx: CFG_ENABLED, default: '0};
        s.it.operation       = op;
        s.it.now_ms          = t;
        s.it.requested_level = req;
        s.it.detector_level  = det;
        s.it.detector_valid  = dv;
        return s;
    endfunction

    function automatic t_stim_row cfg_row(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        t_stim_row s;
        s = '{reg_idx: CFG_ENABLED, default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    // level normal, nothing pending, no refresh
    function automatic t_stim_row quiet_row(input t_stim_row s, input logic st);
        s.pinned               = 1'b1;
        s.want                 = '0;
        s.want.active_level    = LVL_NORMAL;
        s.want.target_level    = LVL_NORMAL;
        s.want.safe_state      = 1'b1;
        s.want.leds            = leds_of(LVL_NORMAL);
        s.want.status          = st;
        return s;
    endfunction

    initial begin : stimulus
        t_stim_row        row;
        t_item            it;
        logic [NOW_W-1:0] clk_ms;
        int               mode;
        int               ph;
        int               k;

        i_rst_n                 = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = CFG_ENABLED;
        cfg_if.data             = '0;
        item_if.valid           = 1'b0;
        item_if.operation       = OP_TICK;
        item_if.now_ms          = '0;
        item_if.requested_level = LVL_NORMAL;
        item_if.detector_level  = LVL_NORMAL;
        item_if.detector_valid  = 1'b0;

        // disabled after reset: both kinds refused
        directed_steps.push_back(quiet_row(item_row(OP_TICK, 0, 0, 4, 1), STATUS_ERR));
        directed_steps.push_back(quiet_row(item_row(OP_REQUEST, 0, 4, 0, 0), STATUS_ERR));
        directed_steps.push_back(cfg_row(CFG_ENABLED, 1));
        directed_steps.push_back(quiet_row(item_row(OP_TICK, 0, 0, 0, 0), STATUS_OK));
        directed_steps.push_back(item_row(OP_TICK, 100, 0, 0, 0));
        // out-of-range request clamps to emergency; same-level request leaves it pending
        directed_steps.push_back(item_row(OP_REQUEST, 200, 7, 0, 0));
        directed_steps.push_back(item_row(OP_REQUEST, 250, 0, 0, 0));
        directed_steps.push_back(item_row(OP_TICK, 250, 0, 0, 0));
        directed_steps.push_back(item_row(OP_TICK, 300, 0, 0, 0));
        // second request replaces the first and restarts the delay
        directed_steps.push_back(item_row(OP_REQUEST, 300, 2, 0, 0));
        directed_steps.push_back(item_row(OP_REQUEST, 310, 1, 0, 0));
        directed_steps.push_back(item_row(OP_TICK, 400, 0, 0, 0));
        directed_steps.push_back(item_row(OP_TICK, 410, 0, 0, 0));
        directed_steps.push_back(item_row(OP_TICK, 420, 0, 7, 1));
        directed_steps.push_back(item_row(OP_TICK, 520, 0, 7, 1));
        directed_steps.push_back(item_row(OP_TICK, 600, 0, 0, 1));
        directed_steps.push_back(cfg_row(CFG_DELAY, 0));
        directed_steps.push_back(cfg_row(CFG_DWELL, 0));
        directed_steps.push_back(cfg_row(CFG_REFRESH, 0));
        directed_steps.push_back(item_row(OP_TICK, 600, 0, 0, 1));
        directed_steps.push_back(item_row(OP_TICK, 600, 0, 0, 1));
        // time wraps through zero
        directed_steps.push_back(item_row(OP_TICK, 32'hFFFF_FFFF, 7, 3, 1));
        directed_steps.push_back(item_row(OP_TICK, 0, 7, 3, 1));
        directed_steps.push_back(cfg_row(CFG_DELAY, 16'hFFFF));
        directed_steps.push_back(cfg_row(CFG_DWELL, 16'hFFFF));
        directed_steps.push_back(cfg_row(CFG_REFRESH, 16'hFFFF));
        directed_steps.push_back(item_row(OP_REQUEST, 32'hFFFF_FFF0, 2, 0, 0));
        directed_steps.push_back(item_row(OP_TICK, 32'h0000_FFEF, 0, 1, 0));
        directed_steps.push_back(item_row(OP_TICK, 32'h0001_0000, 0, 5, 1));
        directed_steps.push_back(cfg_row(CFG_ENABLED, 0));
        directed_steps.push_back(item_row(OP_TICK, 32'h0002_0000, 0, 0, 1));
        directed_steps.push_back(item_row(OP_REQUEST, 32'h0002_0000, 6, 0, 1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
            end else begin
                pinned_reports.push_back(directed_steps[k]);
                send_item(directed_steps[k].it);
            end
        end

        row = '{reg_idx: CFG_ENABLED, default: '0};
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            mode = ph % 4;
            write_reg(CFG_ENABLED, (ph == 5) ? 1'b0 : 1'b1);
            case (mode)
                0: begin
                    write_reg(CFG_DELAY, $urandom_range(0, 40));
                    write_reg(CFG_DWELL, $urandom_range(0, 80));
                    write_reg(CFG_REFRESH, $urandom_range(0, 40));
                end
                1: begin
                    write_reg(CFG_DELAY, 0);
                    write_reg(CFG_DWELL, 0);
                    write_reg(CFG_REFRESH, 0);
                end
                2: begin
                    write_reg(CFG_DELAY, 16'hFFFF);
                    write_reg(CFG_DWELL, 16'hFFFF);
                    write_reg(CFG_REFRESH, 16'hFFFF);
                end
                default: begin
                    write_reg(CFG_DELAY, $urandom);
                    write_reg(CFG_DWELL, $urandom);
                    write_reg(CFG_REFRESH, $urandom);
                end
            endcase
            gaps_on  = (ph < NUM_PHASES - 2);
            stall_on = (ph < NUM_PHASES - 2);
            if (ph == 2)
                hold_off_req = 1'b1;
            clk_ms = $urandom;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                case (mode)
                    0:       clk_ms += $urandom_range(0, 25);
                    1:       clk_ms += $urandom_range(0, 3);
                    2:       clk_ms += $urandom_range(0, 40000);
                    default: clk_ms += $urandom_range(0, 70000);
                endcase
                // occasional jump anywhere, backward included
                if ($urandom_range(0, 31) == 0)
                    clk_ms = $urandom;
                it.operation       = ($urandom_range(0, 3) == 0) ? OP_REQUEST : OP_TICK;
                it.now_ms          = clk_ms;
                it.requested_level = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                                 : $urandom_range(0, 4);
                it.detector_level  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                                 : $urandom_range(0, 4);
                it.detector_valid  = ($urandom_range(0, 4) != 0);
                pinned_reports.push_back(row);
                send_item(it);
            end
        end

        item_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/slef_pkg.sv
hdl/slef_ifaces.sv
hdl/slef_cfg_regs.sv
hdl/slef_in_reg.sv
hdl/slef_core.sv
hdl/safety_level_escalation_fsm.sv
tb/sv/safety_level_escalation_fsm_tb.sv
